[rtl/core/rspt_pkg.sv]
// Shared types and constants of the range sum, point update tree.
package rspt_pkg;

    localparam int NODE_W     = 26;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 16;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    localparam logic [STATUS_W-1:0] STAT_WRITE_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_SUM_VALID    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OUT_OF_RANGE = 2'd2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_QUERY  = 2'd1,
        OP_EMPTY  = 2'd2,
        OP_REJECT = 2'd3
    } rspt_op_t;

    typedef struct packed {
        logic                valid;
        logic [NODE_W-1:0]   total;
        logic [STATUS_W-1:0] status;
    } rspt_res_t;

endpackage

[rtl/core/range_sum_point_update_tree_unit.sv]
// Top level of the range sum, point update tree: stream ports, count register, result slot.
// A write item walks from its leaf up to the root, writing one node per tree level.
// A query item walks both edges of the window upwards, since the single read port
// of the tree memory serves the left and the right edge of the window in alternate cycles.
// Rejected writes and empty queries go straight to the result. One item is in work at a time.
// Reset (rst_n, asynchronous, active low) sets the count to min(1024, MAX_ELEMENTS) and starts
// a clearing pass over all 2 * MAX_ELEMENTS words of the tree memory; no item is taken until it ends.
module range_sum_point_update_tree_unit
    import rspt_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration: element count, written while the block is idle.
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_data,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // elem_index[9:0], elem_value[25:10], range_low[35:26], range_high[45:36], zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[0]
    input  logic [0:0]            s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // range_total[25:0], zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]   m_axis_tuser
);

    localparam int DEPTH  = 2 * MAX_ELEMENTS;
    localparam int PW     = $clog2(DEPTH + 1);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int SEXT_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ELEMENTS);
    localparam logic [CNT_W-1:0] CNT_RST = CNT_W'((MAX_ELEMENTS < 1024) ? MAX_ELEMENTS : 1024);

    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic                  in_mode;
    logic [INDEX_W-1:0]    elem_index;
    logic [VALUE_W-1:0]    elem_value;
    logic [INDEX_W-1:0]    range_low;
    logic [INDEX_W-1:0]    range_high;

    logic [CMP_W-1:0]  idx_ext, lo_ext, hi_ext, cnt_ext, hi_lim, hi_clip;
    logic              value_sign;
    logic [NODE_W-1:0] leaf_value;
    rspt_op_t          op;
    logic [PW-1:0]     span_low, span_high;
    logic              eng_ready;
    logic              start;
    rspt_res_t         res;
    logic              res_take;

    logic                out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]   out_total_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // Unpack the input item.
    assign in_mode    = s_axis_tuser[0];
    assign elem_index = s_axis_tdata[9:0];
    assign elem_value = s_axis_tdata[25:10];
    assign range_low  = s_axis_tdata[35:26];
    assign range_high = s_axis_tdata[45:36];

    // The count register clamps every write into 1 .. MAX_ELEMENTS.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cfg_we)
        begin
            if (cfg_data == '0)
            begin
                cnt_next = CNT_W'(1);
            end
            else if (32'(cfg_data) > 32'(MAX_ELEMENTS))
            begin
                cnt_next = CNT_MAX;
            end
            else
            begin
                cnt_next = CNT_W'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_RST;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // The element value is signed at bit VALUE_BITS-1; wider settings leave it positive.
    always_comb
    begin
        value_sign = (VALUE_BITS <= VALUE_W) ? elem_value[SEXT_W-1] : 1'b0;
        leaf_value = {NODE_W{value_sign}};
        for (int i = 0; i < SEXT_W; i++)
        begin
            leaf_value[i] = elem_value[i];
        end
    end

    // Decode the item into a tree operation. Leaves sit at MAX_ELEMENTS + index; a query
    // walks the half-open window [low, high + 1) after clipping high to the last element.
    assign idx_ext = CMP_W'(elem_index);
    assign lo_ext  = CMP_W'(range_low);
    assign hi_ext  = CMP_W'(range_high);
    assign cnt_ext = CMP_W'(cnt_reg);
    assign hi_lim  = cnt_ext - CMP_W'(1);
    assign hi_clip = (hi_ext > hi_lim) ? hi_lim : hi_ext;

    always_comb
    begin
        span_high = PW'(MAX_ELEMENTS) + PW'(hi_clip) + PW'(1);
        if (in_mode == MODE_WRITE)
        begin
            span_low = PW'(MAX_ELEMENTS) + PW'(elem_index);
            op       = (idx_ext >= cnt_ext) ? OP_REJECT : OP_WRITE;
        end
        else
        begin
            span_low = PW'(MAX_ELEMENTS) + PW'(range_low);
            op       = (lo_ext > hi_clip) ? OP_EMPTY : OP_QUERY;
        end
    end

    assign s_axis_tready = eng_ready;
    assign start         = s_axis_tvalid && eng_ready;

    rspt_engine #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .span_low   (span_low),
        .span_high  (span_high),
        .leaf_value (leaf_value),
        .ready      (eng_ready),
        .res        (res),
        .res_take   (res_take)
    );

    // The result slot: the engine hands over as soon as the slot is empty or draining,
    // so the next item can start while this one waits downstream.
    assign res_take = res.valid && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_total_reg  <= res.total;
            out_status_reg <= res.status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_total_reg);
    assign m_axis_tuser  = out_status_reg;

    // The count in use always lies in 1 .. MAX_ELEMENTS.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0) && (cnt_reg <= CNT_MAX))
        else $error("element count out of range");

    // Writes and rejected writes always report a zero total.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != STAT_SUM_VALID)) |-> (m_axis_tdata == '0))
        else $error("nonzero total on a write result");

    // Only the three defined status codes leave the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STAT_WRITE_DONE ||
                           m_axis_tuser == STAT_SUM_VALID ||
                           m_axis_tuser == STAT_OUT_OF_RANGE))
        else $error("undefined status code");

endmodule

[rtl/core/rspt_engine.sv]
// Tree memory, clearing pass and the update and query walks over it.
module rspt_engine
    import rspt_pkg::*;
#(
    parameter int MAX_ELEMENTS = 1024,
    localparam int DEPTH = 2 * MAX_ELEMENTS,
    localparam int AW = $clog2(DEPTH),
    localparam int PW = $clog2(DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rspt_op_t          op,
    input  logic [PW-1:0]     span_low,
    input  logic [PW-1:0]     span_high,
    input  logic [NODE_W-1:0] leaf_value,
    output logic              ready,
    output rspt_res_t         res,
    input  logic              res_take
);

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_WR_LEAF = 7'b0000100,
        S_WR_UP   = 7'b0001000,
        S_Q_A     = 7'b0010000,
        S_Q_B     = 7'b0100000,
        S_DONE    = 7'b1000000
    } eng_state_t;

    eng_state_t        state_reg, state_next;
    logic [PW-1:0]     a_reg, a_next;
    logic [PW-1:0]     b_reg, b_next;
    logic [NODE_W-1:0] acc_reg, acc_next;
    rspt_op_t          op_reg, op_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [AW-1:0]     clr_reg, clr_next;

    logic [NODE_W-1:0] mem [0:DEPTH-1];
    logic [NODE_W-1:0] rdata_reg;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [NODE_W-1:0] mem_wdata;

    logic [NODE_W-1:0] up_sum;
    logic [PW-1:0]     parent;
    logic [PW-1:0]     b_dec;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign up_sum = acc_reg + rdata_reg;
    assign parent = a_reg >> 1;
    assign b_dec  = b_reg - PW'(b_reg[0]);

    always_comb
    begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        acc_next     = acc_reg;
        op_next      = op_reg;
        clr_next     = clr_reg;
        rd_pend_next = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = a_reg[AW-1:0];
        mem_raddr    = a_reg[AW-1:0];
        mem_wdata    = acc_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    a_next   = span_low;
                    b_next   = span_high;
                    acc_next = '0;
                    unique case (op)
                        OP_WRITE:
                        begin
                            acc_next   = leaf_value;
                            state_next = S_WR_LEAF;
                        end
                        OP_QUERY:  state_next = S_Q_A;
                        OP_EMPTY:  state_next = S_DONE;
                        OP_REJECT: state_next = S_DONE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_WR_LEAF:
            begin
                // Store the leaf and fetch its sibling for the first parent.
                mem_we = 1'b1;
                if (a_reg > PW'(1))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = a_reg[AW-1:0] ^ AW'(1);
                    state_next = S_WR_UP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_WR_UP:
            begin
                // The node value is carried in acc; the sibling just came back.
                mem_we    = 1'b1;
                mem_waddr = parent[AW-1:0];
                mem_wdata = up_sum;
                acc_next  = up_sum;
                a_next    = parent;
                if (parent > PW'(1))
                begin
                    mem_re    = 1'b1;
                    mem_raddr = parent[AW-1:0] ^ AW'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_Q_A:
            begin
                acc_next = acc_reg + (rd_pend_reg ? rdata_reg : '0);
                if (a_reg < b_reg)
                begin
                    if (a_reg[0])
                    begin
                        mem_re       = 1'b1;
                        rd_pend_next = 1'b1;
                        a_next       = a_reg + PW'(1);
                    end
                    state_next = S_Q_B;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_Q_B:
            begin
                acc_next = acc_reg + (rd_pend_reg ? rdata_reg : '0);
                if (b_reg[0])
                begin
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    mem_raddr    = b_dec[AW-1:0];
                end
                a_next     = a_reg >> 1;
                b_next     = b_dec >> 1;
                state_next = S_Q_A;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        op_reg  <= op_next;
    end

    assign ready = (state_reg == S_IDLE);

    always_comb
    begin
        res.valid = (state_reg == S_DONE);
        res.total = acc_reg;
        unique case (op_reg)
            OP_WRITE:  res.status = STAT_WRITE_DONE;
            OP_REJECT: res.status = STAT_OUT_OF_RANGE;
            OP_QUERY,
            OP_EMPTY:  res.status = STAT_SUM_VALID;
            default:   res.status = STAT_SUM_VALID;
        endcase
        if (op_reg == OP_WRITE || op_reg == OP_REJECT)
        begin
            res.total = '0;
        end
    end

    // A read and a write in the same cycle always touch different nodes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("tree read and write hit the same node");

    // The query window never inverts during the walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_A || state_reg == S_Q_B) |-> (a_reg <= b_reg))
        else $error("query window inverted");

    // A new item is never taken while a result is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ready && res.valid))
        else $error("engine ready while holding a result");

    // A query read is accumulated in the cycle after it was issued, still within the query walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> (state_reg == S_Q_A || state_reg == S_Q_B))
        else $error("pending query read outside the query walk");

endmodule

[tb/sv/range_sum_point_update_tree_unit_tb.sv]
// Self-checking testbench of the range sum, point update tree unit.
module range_sum_point_update_tree_unit_tb;

    import rspt_pkg::*;

    localparam int ELEM_SLOTS = 1024;

    // One expected result item: the total and the status that the block must return.
    typedef struct packed {
        logic [NODE_W-1:0]   total;
        logic [STATUS_W-1:0] status;
    } sum_result_t;

    // Scoreboard: keeps its own copy of the element array and the element count,
    // works out the result of every accepted item and checks the returned items in order.
    class range_sum_scoreboard;
        logic signed [VALUE_W-1:0] elems [ELEM_SLOTS];
        int unsigned               count;
        sum_result_t               awaited_q [$];
        int                        errors;

        function new();
            foreach (elems[k])
                elems[k] = '0;
            count  = ELEM_SLOTS;
            errors = 0;
        endfunction

        // A count of zero acts as one, and anything above the array size acts as the size.
        function void set_count(logic [COUNT_W-1:0] raw);
            if (raw == '0)
                count = 1;
            else if (raw > ELEM_SLOTS)
                count = ELEM_SLOTS;
            else
                count = raw;
        endfunction

        function void note_item(logic mode, logic [INDEX_W-1:0] idx,
                                logic signed [VALUE_W-1:0] val,
                                logic [INDEX_W-1:0] lo, logic [INDEX_W-1:0] hi);
            sum_result_t res;
            longint      acc;
            int unsigned top;
            res.total = '0;
            if (mode == MODE_WRITE) begin
                if (idx >= count) begin
                    res.status = STAT_OUT_OF_RANGE;
                end
                else begin
                    elems[idx] = val;
                    res.status = STAT_WRITE_DONE;
                end
            end
            else begin
                top = (hi > count - 1) ? count - 1 : hi;
                acc = 0;
                if (lo <= top) begin
                    for (int k = lo; k <= top; k++)
                        acc += elems[k];
                end
                res.total  = acc[NODE_W-1:0];
                res.status = STAT_SUM_VALID;
            end
            awaited_q.push_back(res);
        endfunction

        function void check_result(logic [NODE_W-1:0] total, logic [STATUS_W-1:0] status);
            sum_result_t res;
            if (awaited_q.size() == 0) begin
                $display("%0t: unexpected result item: total %0d status %0d",
                         $time, $signed(total), status);
                errors++;
                return;
            end
            res = awaited_q.pop_front();
            if (total !== res.total) begin
                $display("%0t: range_total mismatch: expected %0d, actual %0d",
                         $time, $signed(res.total), $signed(total));
                errors++;
            end
            if (status !== res.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, res.status, status);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited_q.size();
        endfunction
    endclass

    // Every input of the block holds a known value from time zero.
    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [COUNT_W-1:0]    cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    range_sum_scoreboard sums = new();

    // When set, both sides insert random idle bursts; cleared for stretches with no idling.
    bit idle_on = 1'b1;
    int stall_left = 0;

    range_sum_point_update_tree_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 clk = ~clk;

    // Result side: an item is taken at every edge where valid and ready are both high.
    // Ready drops in random bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sums.check_result(m_axis_tdata[NODE_W-1:0], m_axis_tuser);
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Presents one item and holds it until the block accepts it. Called right after a
    // rising edge; returns right after the accepting edge. Valid stays high into the
    // next item unless a gap is drawn, so it is never lowered and raised in one step.
    task automatic send_item(input logic mode, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val,
                             input logic [INDEX_W-1:0] lo, input logic [INDEX_W-1:0] hi);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(IN_DATA_W - 2 * INDEX_W - INDEX_W - VALUE_W){1'b0}},
                          hi, lo, val, idx};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sums.note_item(mode, idx, val, lo, hi);
    endtask

    // The fields that an item kind does not use carry random content.
    task automatic send_write(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
        send_item(MODE_WRITE, idx, val, INDEX_W'($urandom), INDEX_W'($urandom));
    endtask

    task automatic send_query(input logic [INDEX_W-1:0] lo, input logic [INDEX_W-1:0] hi);
        send_item(MODE_QUERY, INDEX_W'($urandom), VALUE_W'($urandom), lo, hi);
    endtask

    // Writes the count register once the block is idle. Every item returns a result, so an
    // empty scoreboard means the block has finished; a short pause is kept as a margin.
    task automatic write_count(input logic [COUNT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sums.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sums.set_count(value);
    endtask

    // One random item for the current count. Most writes land inside the elements in use
    // and most queries cover a valid window, so the tree fills and sums are meaningful;
    // the rest are rejected writes, clipped windows and reversed bounds.
    task automatic random_item();
        int unsigned cnt;
        int unsigned sel;
        int unsigned lo;
        int unsigned hi;
        logic [VALUE_W-1:0] val;
        cnt = sums.count;
        if ($urandom_range(0, 1) == 0) begin
            sel = $urandom_range(0, 7);
            if (sel == 0)
                val = $urandom_range(0, 1) ? {1'b1, {(VALUE_W-1){1'b0}}}
                                           : {1'b0, {(VALUE_W-1){1'b1}}};
            else
                val = VALUE_W'($urandom);
            if ($urandom_range(0, 6) == 0)
                send_write(INDEX_W'($urandom), val);
            else
                send_write(INDEX_W'($urandom_range(0, cnt - 1)), val);
        end
        else begin
            sel = $urandom_range(0, 9);
            if (sel <= 5) begin
                lo = $urandom_range(0, cnt - 1);
                hi = $urandom_range(lo, cnt - 1);
            end
            else if (sel <= 7) begin
                lo = $urandom_range(0, ELEM_SLOTS - 1);
                hi = $urandom_range(0, ELEM_SLOTS - 1);
            end
            else if (sel == 8) begin
                lo = $urandom_range(0, cnt - 1);
                hi = $urandom_range(cnt - 1, ELEM_SLOTS - 1);
            end
            else begin
                hi = $urandom_range(0, cnt - 1);
                lo = $urandom_range(hi, ELEM_SLOTS - 1);
            end
            send_query(INDEX_W'(lo), INDEX_W'(hi));
        end
    endtask

    initial
    begin
        logic [COUNT_W-1:0] count_plan [8];
        count_plan = '{11'd64, 11'd1, 11'd2047, 11'd700, 11'd2, 11'd1025,
                       COUNT_W'($urandom_range(3, 1023)), 11'd1024};

        // Reset is held low from time zero; the block then clears its tree memory and
        // keeps ready low until that pass ends, which the handshake waits out.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset count of 1024 elements. The cleared tree must
        // sum to zero, and the value extremes sit at both ends of the array.
        send_query(10'd0, 10'd1023);
        send_write(10'd0, 16'sh8000);
        send_write(10'd1023, 16'sh7FFF);
        send_write(10'd512, 16'shFFFF);
        send_write(10'd511, 16'sh0001);
        send_query(10'd0, 10'd1023);
        send_query(10'd1023, 10'd1023);
        send_query(10'd0, 10'd0);
        send_query(10'd511, 10'd512);
        // A low bound above the high bound gives zero.
        send_query(10'd700, 10'd100);
        send_query(10'd1, 10'd1022);

        // A count of zero acts as one element: writes past index 0 are rejected and
        // every query window is clipped to index 0.
        write_count(11'd0);
        send_write(10'd1, 16'sh0005);
        send_write(10'd1023, 16'sh0007);
        send_write(10'd0, 16'sh0064);
        send_query(10'd0, 10'd1023);
        send_query(10'd1, 10'd1);

        // The largest register value acts as the full array; elements written before the
        // count shrank must still hold their values.
        write_count(11'd2047);
        send_query(10'd0, 10'd1023);
        send_write(10'd1023, 16'sh0000);
        send_query(10'd0, 10'd1023);
        send_query(10'd512, 10'd1023);

        // Random part: one phase per count setting. Two phases run without idling: the fourth,
        // at a count of 700, and the last phase, at the full count.
        for (int p = 0; p < 8; p++) begin
            write_count(count_plan[p]);
            idle_on = (p != 3) && (p != 7);
            repeat (205) random_item();
        end
        s_axis_tvalid <= 1'b0;

        // Wait for the last results, then give the block time to show any extra item.
        while (sums.outstanding() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (sums.errors == 0)
            $display("range_sum_point_update_tree_unit_tb passed");
        else
            $display("range_sum_point_update_tree_unit_tb failed");
        $finish;
    end

    // Guard against a hung handshake: far beyond the slowest correct run.
    initial
    begin
        #(12 * 600000);
        $display("range_sum_point_update_tree_unit_tb failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rspt_pkg.sv
rtl/core/rspt_engine.sv
rtl/core/range_sum_point_update_tree_unit.sv
tb/sv/range_sum_point_update_tree_unit_tb.sv
